@@ hdl/refine_flag_dilate_compact_defines.svh @@
// ----------------------------------------------------------------------------
// refine_flag_dilate_compact assertion macros
// shared concurrent check forms for the flag dilation block
// ----------------------------------------------------------------------------
`ifndef REFINE_FLAG_DILATE_COMPACT_DEFINES_SVH
`define REFINE_FLAG_DILATE_COMPACT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFDC_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfdc same-cycle check failed");

// next-cycle implication, disabled in reset
`define RFDC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfdc next-cycle check failed");

`endif

@@ hdl/rfdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfdc_pkg
// types and constants of the flag dilation and compaction block
// ----------------------------------------------------------------------------
package rfdc_pkg;

    localparam int MAX_SIDE_DEF = 32;

    localparam int GRID_W     = 6;
    localparam int LEVEL_W    = 4;
    localparam int ID_W       = 20;
    localparam int COORD_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);
    localparam logic [ID_W-1:0]   ID_MAX     = {ID_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_START_ID = CFG_IDX_W'(4);

    // request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // dilation window: 4 x 4 x 4 cells, plus one read of the cell itself
    localparam int WIN_CELLS = 64;
    localparam int WK_W      = 7;

    typedef struct packed {
        logic mode;
        logic need_flag;
    } in_item_t;

    typedef struct packed {
        logic               allocate;
        logic [ID_W-1:0]    compact_id;
        logic [LEVEL_W-1:0] level_out;
        logic               own_flag;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic               last;
        logic               error;
    } out_item_t;

endpackage

@@ hdl/rfdc_ram.sv @@
// ----------------------------------------------------------------------------
// rfdc_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rfdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/refine_flag_dilate_compact.sv @@
// ----------------------------------------------------------------------------
// refine_flag_dilate_compact
// loads one level's compute flags, then reports per cell a dilated allocate
// flag and a saturating compacted index
// ----------------------------------------------------------------------------
//  channel | dir | ports                         | moves
//  --------+-----+-------------------------------+-------------------------
//  s_      | in  | s_valid s_ready s_data        | load or fetch request
//  m_      | out | m_valid m_ready m_data        | one cell result
//  cfg_    | in  | cfg_wr_en cfg_index cfg_wdata | register write, no wait
//
//  a load request passes ST_PLANE, ST_TOTAL and ST_DECIDE; an error fetch goes
//  on to ST_EMIT. a fetch request runs the two bit-serial coordinate divisions,
//  then the 65 serial reads of the flag ram (4x4x4 window plus the cell itself)
//  through a 3-stage address pipe; no new request is taken until it is done.
//  reset is synchronous; the flag ram is not cleared, so no clearing pass.
//  a waiting result stalls nothing until the next result is ready to leave.
// ----------------------------------------------------------------------------
`include "refine_flag_dilate_compact_defines.svh"

module refine_flag_dilate_compact #(
    parameter int MAX_SIDE = rfdc_pkg::MAX_SIDE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rfdc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rfdc_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [rfdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import rfdc_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = $clog2(MAX_SIDE);
    localparam int PW     = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int PS_W   = SIDE_W + 2;
    localparam int EXT_W  = SIDE_W + GRID_W;
    localparam int MW     = SIDE_W + CW + 1;
    localparam int AXW    = SIDE_W + PW + 1;
    localparam int TW     = PW + SIDE_W;
    localparam int DC_W   = $clog2(AW + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PLANE  = 8'b0000_0010,
        ST_TOTAL  = 8'b0000_0100,
        ST_DECIDE = 8'b0000_1000,
        ST_DIVZ   = 8'b0001_0000,
        ST_DIVY   = 8'b0010_0000,
        ST_WIN    = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    function automatic logic [SIDE_W-1:0] eff_dim(input logic [GRID_W-1:0] v);
        logic [EXT_W-1:0]  ve;
        logic [SIDE_W-1:0] r;
        ve = EXT_W'(v);
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (ve > EXT_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    // offset rule along one axis: even coordinate -1..+2, odd -2..+1
    function automatic logic [CW-1:0] axis_pos(input logic [CW-1:0] c,
                                               input logic [1:0] j,
                                               input logic [SIDE_W-1:0] n);
        logic signed [PS_W-1:0] p;
        logic signed [PS_W-1:0] top;
        logic [CW-1:0]          r;
        p   = $signed(PS_W'(c)) + $signed(PS_W'(j))
              - (c[0] ? $signed(PS_W'(2)) : $signed(PS_W'(1)));
        top = $signed(PS_W'(n)) - $signed(PS_W'(1));
        if (p < 0 || p > top) begin
            r = c;
        end else begin
            r = CW'(p);
        end
        return r;
    endfunction

    // configuration
    logic [GRID_W-1:0]  grid_x_reg, grid_y_reg, grid_z_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [ID_W-1:0]    start_id_reg;
    logic [SIDE_W-1:0]  nx, ny, nz;

    // control
    state_t             state_reg;
    logic               mode_reg;
    logic               cal_reg;
    logic [PW-1:0]      plane_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   fetch_cnt_reg;
    logic [ID_W-1:0]    running_id_reg;
    logic               full_reg;
    logic               err_reg;
    logic               last_reg;
    logic [AW-1:0]      idx_reg;
    logic [CW-1:0]      x_reg, y_reg, z_reg;

    // shared divider
    logic [AW-1:0]      div_num_reg;
    logic [PW:0]        div_rem_reg;
    logic [PW-1:0]      div_den_reg;
    logic [AW-1:0]      div_quo_reg;
    logic [DC_W-1:0]    div_cnt_reg;
    logic [PW:0]        div_shift;
    logic               div_ge;
    logic [PW:0]        div_rem_next;
    logic [AW-1:0]      div_quo_next;

    // window read pipe
    logic [WK_W-1:0]    win_k_reg;
    logic               win_own;
    logic               win_issue;
    logic               win_done;
    logic               pa_v_reg, pa_own_reg;
    logic [CW-1:0]      pa_x_reg, pa_y_reg, pa_z_reg;
    logic               pb_v_reg, pb_own_reg;
    logic [CW-1:0]      pb_x_reg;
    logic [PW-1:0]      pb_t_reg;
    logic [MW-1:0]      t_wide;
    logic [AXW-1:0]     addr_wide;
    logic               rd_v_reg, rd_own_reg;
    logic               alloc_reg, own_reg;

    // load and fetch decisions
    logic               load_lt;
    logic [CNT_W-1:0]   load_cnt_next;
    logic               ram_we;
    logic               ram_rdata;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W:0]     idx_inc;

    logic               m_valid_reg;
    out_item_t          m_data_reg;
    out_item_t          result_item;
    logic               emit_go;

    assign nx = eff_dim(grid_x_reg);
    assign ny = eff_dim(grid_y_reg);
    assign nz = eff_dim(grid_z_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_x_reg   <= GRID_RESET;
            grid_y_reg   <= GRID_RESET;
            grid_z_reg   <= GRID_RESET;
            level_reg    <= '0;
            start_id_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_X:   grid_x_reg   <= cfg_wdata[GRID_W-1:0];
                REG_GRID_Y:   grid_y_reg   <= cfg_wdata[GRID_W-1:0];
                REG_GRID_Z:   grid_z_reg   <= cfg_wdata[GRID_W-1:0];
                REG_LEVEL:    level_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_START_ID: start_id_reg <= cfg_wdata[ID_W-1:0];
                default: ;
            endcase
        end
    end

    // load step
    assign load_lt       = (load_cnt_reg < total_reg);
    assign load_cnt_next = load_lt ? load_cnt_reg + CNT_W'(1) : load_cnt_reg;
    assign ram_we        = (state_reg == ST_DECIDE) && (mode_reg == MODE_LOAD)
                           && !full_reg && load_lt;

    // fetch cell index, held to the final cell
    assign idx_next = (fetch_cnt_reg < total_reg) ? fetch_cnt_reg : total_reg - CNT_W'(1);
    assign idx_inc  = (CNT_W + 1)'(idx_next) + (CNT_W + 1)'(1);

    // restoring divider, one quotient bit a cycle
    assign div_shift    = {div_rem_reg[PW-1:0], div_num_reg[AW-1]};
    assign div_ge       = (div_shift >= {1'b0, div_den_reg});
    assign div_rem_next = div_ge ? div_shift - {1'b0, div_den_reg} : div_shift;
    assign div_quo_next = {div_quo_reg[AW-2:0], div_ge};

    // window address generation
    assign win_own   = win_k_reg[WK_W-1];
    assign win_issue = (state_reg == ST_WIN) && (win_k_reg <= WK_W'(WIN_CELLS));
    assign win_done  = (state_reg == ST_WIN) && (win_k_reg == WK_W'(WIN_CELLS + 1))
                       && !pa_v_reg && !pb_v_reg && !rd_v_reg;
    assign t_wide    = MW'(ny) * MW'(pa_z_reg) + MW'(pa_y_reg);
    assign addr_wide = AXW'(nx) * AXW'(pb_t_reg) + AXW'(pb_x_reg);

    rfdc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flag_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (load_cnt_reg[AW-1:0]),
        .wr_data (cal_reg),
        .rd_en   (pb_v_reg),
        .rd_addr (AW'(addr_wide)),
        .rd_data (ram_rdata)
    );

    always_comb begin
        result_item           = '0;
        result_item.level_out = level_reg;
        result_item.error     = err_reg;
        if (!err_reg) begin
            result_item.allocate   = alloc_reg;
            result_item.compact_id = running_id_reg;
            result_item.own_flag   = own_reg;
            result_item.cell_x     = COORD_W'(x_reg);
            result_item.cell_y     = COORD_W'(y_reg);
            result_item.cell_z     = COORD_W'(z_reg);
            result_item.last       = last_reg;
        end
    end

    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // window pipe: position, partial index, ram address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_v_reg <= 1'b0;
            pb_v_reg <= 1'b0;
            rd_v_reg <= 1'b0;
        end else begin
            pa_v_reg <= win_issue;
            pb_v_reg <= pa_v_reg;
            rd_v_reg <= pb_v_reg;
        end
        pa_own_reg <= win_own;
        pa_x_reg   <= win_own ? x_reg : axis_pos(x_reg, win_k_reg[1:0], nx);
        pa_y_reg   <= win_own ? y_reg : axis_pos(y_reg, win_k_reg[3:2], ny);
        pa_z_reg   <= win_own ? z_reg : axis_pos(z_reg, win_k_reg[5:4], nz);
        pb_own_reg <= pa_own_reg;
        pb_x_reg   <= pa_x_reg;
        pb_t_reg   <= PW'(t_wide);
        rd_own_reg <= pb_own_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            load_cnt_reg   <= '0;
            fetch_cnt_reg  <= '0;
            running_id_reg <= '0;
            full_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_data.mode;
                        cal_reg   <= s_data.need_flag;
                        state_reg <= ST_PLANE;
                    end
                end
                ST_PLANE: begin
                    plane_reg <= PW'(PW'(nx) * PW'(ny));
                    state_reg <= ST_TOTAL;
                end
                ST_TOTAL: begin
                    total_reg <= CNT_W'(TW'(plane_reg) * TW'(nz));
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (mode_reg == MODE_LOAD) begin
                        if (!full_reg) begin
                            load_cnt_reg <= load_cnt_next;
                            if (load_cnt_next >= total_reg) begin
                                full_reg       <= 1'b1;
                                fetch_cnt_reg  <= '0;
                                running_id_reg <= start_id_reg;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end else if (!full_reg) begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        err_reg     <= 1'b0;
                        idx_reg     <= AW'(idx_next);
                        last_reg    <= (idx_inc >= (CNT_W + 1)'(total_reg));
                        div_num_reg <= AW'(idx_next);
                        div_rem_reg <= '0;
                        div_quo_reg <= '0;
                        div_den_reg <= plane_reg;
                        div_cnt_reg <= DC_W'(AW);
                        state_reg   <= ST_DIVZ;
                    end
                end
                ST_DIVZ: begin
                    if (div_cnt_reg == DC_W'(1)) begin
                        z_reg       <= CW'(div_quo_next);
                        div_num_reg <= AW'(div_rem_next);
                        div_rem_reg <= '0;
                        div_quo_reg <= '0;
                        div_den_reg <= PW'(nx);
                        div_cnt_reg <= DC_W'(AW);
                        state_reg   <= ST_DIVY;
                    end else begin
                        div_rem_reg <= div_rem_next;
                        div_quo_reg <= div_quo_next;
                        div_num_reg <= {div_num_reg[AW-2:0], 1'b0};
                        div_cnt_reg <= div_cnt_reg - DC_W'(1);
                    end
                end
                ST_DIVY: begin
                    div_rem_reg <= div_rem_next;
                    div_quo_reg <= div_quo_next;
                    div_num_reg <= {div_num_reg[AW-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - DC_W'(1);
                    if (div_cnt_reg == DC_W'(1)) begin
                        y_reg     <= CW'(div_quo_next);
                        x_reg     <= CW'(div_rem_next);
                        win_k_reg <= '0;
                        alloc_reg <= 1'b0;
                        own_reg   <= 1'b0;
                        state_reg <= ST_WIN;
                    end
                end
                ST_WIN: begin
                    if (win_issue) begin
                        win_k_reg <= win_k_reg + WK_W'(1);
                    end
                    if (rd_v_reg) begin
                        if (rd_own_reg) begin
                            own_reg <= ram_rdata;
                        end else begin
                            alloc_reg <= alloc_reg | ram_rdata;
                        end
                    end
                    if (win_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_data_reg <= result_item;
                        if (!err_reg) begin
                            if (alloc_reg && running_id_reg != ID_MAX) begin
                                running_id_reg <= running_id_reg + ID_W'(1);
                            end
                            fetch_cnt_reg <= CNT_W'(idx_reg) + CNT_W'(1);
                            if (last_reg) begin
                                full_reg     <= 1'b0;
                                load_cnt_reg <= '0;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `RFDC_ASSERT_NOW(a_idle_pipe_empty, aclk, aresetn, s_ready, !pa_v_reg && !pb_v_reg && !rd_v_reg)
    `RFDC_ASSERT_NOW(a_write_only_loading, aclk, aresetn, ram_we, !full_reg && !pb_v_reg)
    `RFDC_ASSERT_NOW(a_error_result_clean, aclk, aresetn, m_valid && m_data.error, !m_data.allocate && !m_data.last)
    `RFDC_ASSERT_NEXT(a_result_from_emit, aclk, aresetn, emit_go, m_valid && state_reg == ST_IDLE)

endmodule
